@@ rtl/core/csqr_pkg.sv @@
// ----------------------------------------------------------------------------
// csqr_pkg
// shared types and constants for the command send queue with retry
// ----------------------------------------------------------------------------
`default_nettype none

package csqr_pkg;

  // default ring depth of the command store
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // configuration register reset values
  localparam logic [3:0] RETRY_LIMIT_RST = 4'd1;
  localparam logic [7:0] STALL_LIMIT_RST = 8'd10;

  // stall counter saturation point
  localparam logic [7:0] STALL_MAX = 8'hFF;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_FAIL    = 2'd2,
    ACT_TICK    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    LINK_SENT       = 2'd0,
    LINK_BUSY_BEGIN = 2'd1,
    LINK_WRITE_ERR  = 2'd2,
    LINK_BUSY_SEND  = 2'd3
  } link_e;

  typedef enum logic [1:0] {
    REP_NONE      = 2'd0,
    REP_STUCK     = 2'd1,
    REP_NO_ANSWER = 2'd2,
    REP_WRITE_ERR = 2'd3
  } report_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RETRY_LIMIT = 1'd0,
    CFG_STALL_LIMIT = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_READ = 2'd2,
    ST_LOAD = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  cmd_code;
    logic [15:0] cmd_argument;
    logic [15:0] list_number;
    logic [7:0]  request_tag;
    logic [1:0]  link_status;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        launch_valid;
    logic [7:0]  out_cmd;
    logic [15:0] out_argument;
    logic [15:0] out_list;
    logic [7:0]  out_request;
    logic [1:0]  drop_report;
    logic [2:0]  queue_level;
    logic        busy_flag;
  } out_item_t;

  // one slot of the command store
  typedef struct packed {
    logic [7:0]  code;
    logic [15:0] argument;
    logic [15:0] list;
    logic [7:0]  tag;
  } cmd_entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
    logic read;
    logic load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/csqr_ctrl.sv @@
// ----------------------------------------------------------------------------
// csqr_ctrl
// sequencer: capture, execute event, read head slot, load result
// ----------------------------------------------------------------------------
`default_nettype none

module csqr_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  csqr_pkg::dp_sts_t     sts_i,
  output csqr_pkg::ctl_cmd_t    cmd_o
);

  csqr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csqr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csqr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = csqr_pkg::ST_EXEC;
        end
      end
      csqr_pkg::ST_EXEC: state_d = csqr_pkg::ST_READ;
      csqr_pkg::ST_READ: state_d = csqr_pkg::ST_LOAD;
      csqr_pkg::ST_LOAD: begin
        if (sts_i.out_free) begin
          state_d = csqr_pkg::ST_IDLE;
        end
      end
      default: state_d = csqr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      csqr_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      csqr_pkg::ST_EXEC: cmd_o.commit = 1'b1;
      csqr_pkg::ST_READ: cmd_o.read = 1'b1;
      csqr_pkg::ST_LOAD: cmd_o.load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> sts_i.out_free)
    else $error("result loaded into an occupied output register");

  a_exec_follows_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.commit)
    else $error("captured transaction not executed next cycle");

endmodule

`default_nettype wire

@@ rtl/core/csqr_dpath.sv @@
// ----------------------------------------------------------------------------
// csqr_dpath
// command ring, counters, configuration registers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module csqr_dpath #(
  parameter int unsigned QUEUE_DEPTH = csqr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  csqr_pkg::ctl_cmd_t                  cmd_i,
  output csqr_pkg::dp_sts_t                   sts_o,
  input  csqr_pkg::in_item_t                  in_item_i,
  input  wire                                 cfg_we_i,
  input  wire [csqr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [csqr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output csqr_pkg::out_item_t                 out_item_o
);

  localparam int unsigned PtrW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW  = FillW + 1;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // configuration
  logic [3:0] retry_limit_q;
  logic [7:0] stall_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= csqr_pkg::RETRY_LIMIT_RST;
      stall_limit_q <= csqr_pkg::STALL_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (csqr_pkg::cfg_reg_e'(cfg_index_i))
        csqr_pkg::CFG_RETRY_LIMIT: retry_limit_q <= cfg_data_i[3:0];
        csqr_pkg::CFG_STALL_LIMIT: stall_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured transaction
  csqr_pkg::in_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
  end

  // queue state
  logic [PtrW-1:0]  head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             inflight_q, inflight_d;
  logic [3:0]       retry_q, retry_d;
  logic [7:0]       stall_q, stall_d;
  logic             armed_q, armed_d;

  // pending result fields
  logic             acc_d, acc_q;
  logic             launch_d, launch_q;
  logic [1:0]       rep_d, rep_q;

  logic [SumW-1:0]  tail_sum;
  logic [PtrW-1:0]  tail_ptr;
  logic             try_l;

  always_comb begin
    tail_sum = SumW'(head_q) + SumW'(fill_q);
    if (tail_sum >= SumW'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SumW'(QUEUE_DEPTH);
    end
    tail_ptr = tail_sum[PtrW-1:0];
  end

  // event then launch try
  always_comb begin
    head_d     = head_q;
    fill_d     = fill_q;
    inflight_d = inflight_q;
    retry_d    = retry_q;
    stall_d    = stall_q;
    armed_d    = armed_q;
    acc_d      = 1'b0;
    launch_d   = 1'b0;
    rep_d      = csqr_pkg::REP_NONE;
    try_l      = 1'b0;

    unique case (csqr_pkg::action_e'(item_q.action))
      csqr_pkg::ACT_ENQUEUE: begin
        if (fill_d != FillW'(QUEUE_DEPTH)) begin
          fill_d = fill_d + 1'b1;
          acc_d  = 1'b1;
          try_l  = 1'b1;
        end
      end
      csqr_pkg::ACT_ACK: begin
        inflight_d = 1'b0;
        if (fill_d != '0) begin
          head_d  = ptr_inc(head_d);
          fill_d  = fill_d - 1'b1;
          retry_d = '0;
          stall_d = '0;
        end
        try_l = 1'b1;
      end
      csqr_pkg::ACT_FAIL: begin
        inflight_d = 1'b0;
        if (fill_d != '0) begin
          if (retry_d < retry_limit_q) begin
            retry_d = retry_d + 1'b1;
          end else begin
            head_d  = ptr_inc(head_d);
            fill_d  = fill_d - 1'b1;
            retry_d = '0;
            stall_d = '0;
            rep_d   = csqr_pkg::REP_NO_ANSWER;
          end
          try_l = 1'b1;
        end
      end
      csqr_pkg::ACT_TICK: begin
        armed_d = 1'b0;
        try_l   = 1'b1;
      end
      default: ;
    endcase

    if (try_l && !inflight_d && (fill_d != '0)) begin
      if (csqr_pkg::link_e'(item_q.link_status) == csqr_pkg::LINK_SENT) begin
        launch_d   = 1'b1;
        stall_d    = '0;
        inflight_d = 1'b1;
      end else begin
        // write error drops the head before counting the stall
        if (csqr_pkg::link_e'(item_q.link_status) == csqr_pkg::LINK_WRITE_ERR) begin
          head_d  = ptr_inc(head_d);
          fill_d  = fill_d - 1'b1;
          retry_d = '0;
          stall_d = '0;
          rep_d   = csqr_pkg::REP_WRITE_ERR;
        end
        if (stall_d != csqr_pkg::STALL_MAX) begin
          stall_d = stall_d + 1'b1;
        end
        if (stall_d > stall_limit_q) begin
          if (fill_d != '0) begin
            head_d = ptr_inc(head_d);
            fill_d = fill_d - 1'b1;
          end
          retry_d = '0;
          stall_d = '0;
          rep_d   = csqr_pkg::REP_STUCK;
        end
        if (fill_d != '0) begin
          armed_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      fill_q     <= '0;
      inflight_q <= 1'b0;
      retry_q    <= '0;
      stall_q    <= '0;
      armed_q    <= 1'b0;
    end else if (cmd_i.commit) begin
      head_q     <= head_d;
      fill_q     <= fill_d;
      inflight_q <= inflight_d;
      retry_q    <= retry_d;
      stall_q    <= stall_d;
      armed_q    <= armed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      acc_q    <= acc_d;
      launch_q <= launch_d;
      rep_q    <= rep_d;
    end
  end

  // command store
  csqr_pkg::cmd_entry_t mem_q [QUEUE_DEPTH];
  csqr_pkg::cmd_entry_t rd_q;
  csqr_pkg::cmd_entry_t wr_entry;

  assign wr_entry = '{code:     item_q.cmd_code,
                      argument: item_q.cmd_argument,
                      list:     item_q.list_number,
                      tag:      item_q.request_tag};

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && acc_d) begin
      mem_q[tail_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_q <= mem_q[head_q];
    end
  end

  // result register
  logic                 out_valid_q;
  csqr_pkg::out_item_t  out_item_q;
  csqr_pkg::out_item_t  res_d;
  logic [FillW+2:0]     lvl_ext;

  assign lvl_ext = {3'b000, fill_q};

  always_comb begin
    res_d              = '0;
    res_d.accepted     = acc_q;
    res_d.launch_valid = launch_q;
    res_d.drop_report  = rep_q;
    res_d.queue_level  = lvl_ext[2:0];
    res_d.busy_flag    = inflight_q;
    if (launch_q) begin
      res_d.out_cmd      = rd_q.code;
      res_d.out_argument = rd_q.argument;
      res_d.out_list     = rd_q.list;
      res_d.out_request  = rd_q.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_item_q <= res_d;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_item_q;

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  a_launch_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && launch_d) |=> inflight_q && (fill_q != '0))
    else $error("launch without a held command in flight");

  a_accept_grows_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && acc_d) |-> (fill_q != FillW'(QUEUE_DEPTH)))
    else $error("enqueue taken on a full queue");

endmodule

`default_nettype wire

@@ rtl/core/command_send_queue_with_retry.sv @@
// ----------------------------------------------------------------------------
// command_send_queue_with_retry
// command transmit queue with launch, retry and stall-drop handling
// ----------------------------------------------------------------------------
// sequence: each accepted transaction passes capture, execute, head slot read
//   and load; the load waits while back-pressure holds the result register
// throughput: no new transaction is taken until the current one's result is
//   loaded into the result register
// reset: asynchronous active low; queue empty, counters and flags cleared,
//   retry_limit 1, stall_limit 10; command store contents are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module command_send_queue_with_retry #(
  parameter int unsigned QUEUE_DEPTH = csqr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // event channel
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  csqr_pkg::in_item_t               in_item_i,
  // result channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output csqr_pkg::out_item_t              out_item_o,
  // configuration write channel
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [csqr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [csqr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  csqr_pkg::ctl_cmd_t ctl_cmd;
  csqr_pkg::dp_sts_t  dp_sts;

  // configuration registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: one transaction in flight inside the block at a time, the
  // result register lets the next transaction be taken while a result waits
  csqr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctl_cmd)
  );

  // datapath: ring of commands, retry and stall counters, launch decision
  csqr_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctl_cmd),
    .sts_o       (dp_sts),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transaction taken while one is being processed");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the command send queue with retry
// ----------------------------------------------------------------------------
// A queue of pending events is filled by the stimulus sequence. A clocked
// driver feeds that queue onto the event channel. At each accepted
// transaction the driver updates a bit-accurate predictor of the ring,
// retry and stall logic and pushes the predicted outcome. A clocked monitor
// compares every accepted result with the oldest predicted outcome, field by
// field. Limits are changed only between phases, once the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int unsigned DEPTH = csqr_pkg::QUEUE_DEPTH_DEF;

  logic clk_i;
  logic rst_ni = 1'b0;

  // event channel
  logic                          in_valid = 1'b0;
  logic                          in_stall_o;
  csqr_pkg::in_item_t            in_item  = '0;
  // result channel
  logic                          out_valid_o;
  logic                          out_stall = 1'b0;
  csqr_pkg::out_item_t           out_item_o;
  // configuration write channel
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready_o;
  logic [csqr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [csqr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  command_send_queue_with_retry DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // bench bookkeeping
  // --------------------------------------------------------------------------
  csqr_pkg::in_item_t  event_q[$];      // events waiting to be driven
  csqr_pkg::out_item_t outcome_q[$];    // predicted results, oldest first
  int unsigned events_queued = 0;
  int unsigned events_taken  = 0;
  int unsigned gap_pct       = 34;  // chance of an idle cycle on either side
  bit          failed        = 1'b0;

  // --------------------------------------------------------------------------
  // predictor state: ring of commands, link and retry bookkeeping, limits
  // --------------------------------------------------------------------------
  csqr_pkg::cmd_entry_t ring [DEPTH];
  int unsigned ring_head;
  int unsigned ring_fill;
  logic        link_busy;     // a command is in flight
  logic [3:0]  retries;
  logic [7:0]  stalls;
  logic        retry_armed;
  logic [3:0]  retry_lim;
  logic [7:0]  stall_lim;

  // per-event scratch
  csqr_pkg::report_e    step_report;
  logic                 step_launch;
  csqr_pkg::cmd_entry_t step_entry;

  // drop the head (if any) and clear both counters
  function automatic void retire_head();
    if (ring_fill > 0) begin
      ring_head = (ring_head + 1) % DEPTH;
      ring_fill--;
    end
    retries = '0;
    stalls  = '0;
  endfunction

  // busy link: count a stall, drop the head as stuck once over the limit
  function automatic void count_busy();
    if (stalls != csqr_pkg::STALL_MAX) stalls++;
    if (stalls > stall_lim) begin
      retire_head();
      step_report = csqr_pkg::REP_STUCK;
    end
    if (!retry_armed && ring_fill > 0) retry_armed = 1'b1;
  endfunction

  // launch attempt on the head, only with nothing in flight and a non-empty ring
  function automatic void try_send(csqr_pkg::link_e st);
    if (!link_busy && ring_fill != 0) begin
      unique case (st)
        csqr_pkg::LINK_SENT: begin
          step_entry  = ring[ring_head];
          step_launch = 1'b1;
          stalls      = '0;
          link_busy   = 1'b1;
        end
        csqr_pkg::LINK_WRITE_ERR: begin
          // the head goes, then the failed write still counts as a stall
          retire_head();
          step_report = csqr_pkg::REP_WRITE_ERR;
          count_busy();
        end
        default: count_busy();
      endcase
    end
  endfunction

  // advance the predictor by one event and return the result it should give
  function automatic csqr_pkg::out_item_t apply_event(csqr_pkg::in_item_t ev);
    csqr_pkg::out_item_t res;
    csqr_pkg::link_e     st;
    st          = csqr_pkg::link_e'(ev.link_status);
    res         = '0;
    step_report = csqr_pkg::REP_NONE;
    step_launch = 1'b0;
    step_entry  = '0;
    unique case (csqr_pkg::action_e'(ev.action))
      csqr_pkg::ACT_ENQUEUE: begin
        // a full ring refuses the command and tries no launch
        if (ring_fill < DEPTH) begin
          ring[(ring_head + ring_fill) % DEPTH] =
            {ev.cmd_code, ev.cmd_argument, ev.list_number, ev.request_tag};
          ring_fill++;
          res.accepted = 1'b1;
          try_send(st);
        end
      end
      csqr_pkg::ACT_ACK: begin
        link_busy = 1'b0;
        if (ring_fill > 0) retire_head();
        try_send(st);
      end
      csqr_pkg::ACT_FAIL: begin
        link_busy = 1'b0;
        // failure on an empty ring does nothing at all
        if (ring_fill > 0) begin
          if (retries < retry_lim) begin
            retries++;
          end else begin
            retire_head();
            step_report = csqr_pkg::REP_NO_ANSWER;
          end
          try_send(st);
        end
      end
      default: begin
        retry_armed = 1'b0;
        try_send(st);
      end
    endcase
    res.launch_valid = step_launch;
    res.out_cmd      = step_entry.code;
    res.out_argument = step_entry.argument;
    res.out_list     = step_entry.list;
    res.out_request  = step_entry.tag;
    res.drop_report  = step_report;
    res.queue_level  = 3'(ring_fill);
    res.busy_flag    = link_busy;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // driver: one event per transaction, random gaps, payload held while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      // transaction accepted at this edge: predict its outcome
      if (in_valid && !in_stall_o) begin
        outcome_q.push_back(apply_event(in_item));
        events_taken++;
      end
      // a new event may only be offered once the current one has gone
      if (!in_valid || !in_stall_o) begin
        if (event_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_valid <= 1'b1;
          in_item  <= event_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random back-pressure and field-by-field comparison
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    csqr_pkg::out_item_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result transaction with no outcome pending");
          failed = 1'b1;
        end else begin
          want = outcome_q.pop_front();
          check_field("accepted", 16'(want.accepted), 16'(out_item_o.accepted));
          check_field("launch_valid", 16'(want.launch_valid),
                      16'(out_item_o.launch_valid));
          check_field("out_cmd", 16'(want.out_cmd), 16'(out_item_o.out_cmd));
          check_field("out_argument", want.out_argument, out_item_o.out_argument);
          check_field("out_list", want.out_list, out_item_o.out_list);
          check_field("out_request", 16'(want.out_request),
                      16'(out_item_o.out_request));
          check_field("drop_report", 16'(want.drop_report),
                      16'(out_item_o.drop_report));
          check_field("queue_level", 16'(want.queue_level),
                      16'(out_item_o.queue_level));
          check_field("busy_flag", 16'(want.busy_flag), 16'(out_item_o.busy_flag));
        end
      end
      out_stall <= ($urandom_range(99) < gap_pct);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic csqr_pkg::in_item_t make_event(csqr_pkg::action_e act,
                                                    csqr_pkg::link_e st);
    csqr_pkg::in_item_t ev;
    ev.action       = act;
    ev.cmd_code     = 8'($urandom);
    ev.cmd_argument = 16'($urandom);
    ev.list_number  = 16'($urandom);
    ev.request_tag  = 8'($urandom);
    ev.link_status  = st;
    return ev;
  endfunction

  task automatic push_event(csqr_pkg::in_item_t ev);
    event_q.push_back(ev);
    events_queued++;
  endtask

  // random events; busy_pct sets how often the link is busy on a launch try
  task automatic push_random(int unsigned n, int unsigned busy_pct);
    int unsigned       r;
    csqr_pkg::action_e act;
    csqr_pkg::link_e   st;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 35)      act = csqr_pkg::ACT_ENQUEUE;
      else if (r < 60) act = csqr_pkg::ACT_ACK;
      else if (r < 80) act = csqr_pkg::ACT_FAIL;
      else             act = csqr_pkg::ACT_TICK;
      r = $urandom_range(99);
      if (r < busy_pct)
        st = $urandom_range(1) ? csqr_pkg::LINK_BUSY_BEGIN : csqr_pkg::LINK_BUSY_SEND;
      else if (r < busy_pct + 8)
        st = csqr_pkg::LINK_WRITE_ERR;
      else
        st = csqr_pkg::LINK_SENT;
      push_event(make_event(act, st));
    end
  endtask

  // wait until every event is taken and every outcome checked, then let
  // the pipeline settle for longer than its latency
  task automatic drain();
    while (events_taken != events_queued || outcome_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // register write, only called with the block idle
  task automatic write_reg(csqr_pkg::cfg_reg_e idx, logic [7:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == csqr_pkg::CFG_RETRY_LIMIT) retry_lim = value[3:0];
    else                                  stall_lim = value;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    csqr_pkg::in_item_t ev;

    // predictor reset state
    ring_head   = 0;
    ring_fill   = 0;
    link_busy   = 1'b0;
    retries     = '0;
    stalls      = '0;
    retry_armed = 1'b0;
    retry_lim   = csqr_pkg::RETRY_LIMIT_RST;
    stall_lim   = csqr_pkg::STALL_LIMIT_RST;
    foreach (ring[i]) ring[i] = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- phase 0: reset limits (retry 1, stall 10), directed then random
    ev = make_event(csqr_pkg::ACT_ENQUEUE, csqr_pkg::LINK_SENT); // all-ones, launched
    ev.cmd_code = '1; ev.cmd_argument = '1; ev.list_number = '1; ev.request_tag = '1;
    push_event(ev);
    ev = make_event(csqr_pkg::ACT_ENQUEUE, csqr_pkg::LINK_SENT); // all-zeros, queued
    ev.cmd_code = '0; ev.cmd_argument = '0; ev.list_number = '0; ev.request_tag = '0;
    push_event(ev);
    push_event(make_event(csqr_pkg::ACT_ACK,  csqr_pkg::LINK_SENT)); // pop, launch next
    push_event(make_event(csqr_pkg::ACT_FAIL, csqr_pkg::LINK_BUSY_BEGIN)); // retried
    push_event(make_event(csqr_pkg::ACT_FAIL, csqr_pkg::LINK_SENT)); // no answer
    push_event(make_event(csqr_pkg::ACT_FAIL, csqr_pkg::LINK_SENT)); // empty queue
    push_event(make_event(csqr_pkg::ACT_ACK,  csqr_pkg::LINK_SENT)); // nothing in flight
    push_event(make_event(csqr_pkg::ACT_TICK, csqr_pkg::LINK_SENT)); // nothing queued
    push_event(make_event(csqr_pkg::ACT_ENQUEUE, csqr_pkg::LINK_BUSY_SEND));
    push_event(make_event(csqr_pkg::ACT_TICK,    csqr_pkg::LINK_BUSY_BEGIN));
    push_event(make_event(csqr_pkg::ACT_TICK,    csqr_pkg::LINK_WRITE_ERR)); // stall 1
    repeat (4) push_event(make_event(csqr_pkg::ACT_ENQUEUE, csqr_pkg::LINK_BUSY_BEGIN));
    push_event(make_event(csqr_pkg::ACT_ENQUEUE, csqr_pkg::LINK_SENT)); // full: refused
    push_event(make_event(csqr_pkg::ACT_TICK,    csqr_pkg::LINK_SENT));
    push_event(make_event(csqr_pkg::ACT_ACK,     csqr_pkg::LINK_SENT));
    push_event(make_event(csqr_pkg::ACT_ENQUEUE, csqr_pkg::LINK_SENT)); // behind in-flight
    push_event(make_event(csqr_pkg::ACT_TICK,    csqr_pkg::LINK_SENT)); // in flight
    push_random(380, 30);
    drain();

    // ---- phase 1: both limits at zero
    write_reg(csqr_pkg::CFG_RETRY_LIMIT, {4'($urandom), 4'd0});
    write_reg(csqr_pkg::CFG_STALL_LIMIT, 8'd0);
    repeat (5) push_event(make_event(csqr_pkg::ACT_ACK, csqr_pkg::LINK_SENT)); // empty
    push_event(make_event(csqr_pkg::ACT_ENQUEUE, csqr_pkg::LINK_WRITE_ERR)); // then stuck
    push_event(make_event(csqr_pkg::ACT_ENQUEUE, csqr_pkg::LINK_BUSY_BEGIN)); // too many
    push_event(make_event(csqr_pkg::ACT_ENQUEUE, csqr_pkg::LINK_SENT));
    push_event(make_event(csqr_pkg::ACT_FAIL,    csqr_pkg::LINK_SENT)); // no retry allowed
    push_random(300, 25);
    drain();

    // ---- phase 2: retry limit at its top (15), stall limit 254, with a long busy run
    write_reg(csqr_pkg::CFG_RETRY_LIMIT, {4'($urandom), 4'd15});
    write_reg(csqr_pkg::CFG_STALL_LIMIT, 8'd254);
    push_event(make_event(csqr_pkg::ACT_ACK,     csqr_pkg::LINK_BUSY_BEGIN));
    push_event(make_event(csqr_pkg::ACT_ENQUEUE, csqr_pkg::LINK_BUSY_SEND));
    repeat (258)
      push_event(make_event(csqr_pkg::ACT_TICK, $urandom_range(1) ?
                            csqr_pkg::LINK_BUSY_BEGIN : csqr_pkg::LINK_BUSY_SEND));
    push_random(300, 60);
    drain();

    // ---- phase 3: mid limits, no idling on either side
    gap_pct = 0;
    write_reg(csqr_pkg::CFG_RETRY_LIMIT, {4'($urandom), 4'd7});
    write_reg(csqr_pkg::CFG_STALL_LIMIT, 8'd3);
    push_random(400, 40);
    drain();
    gap_pct = 34;

    // ---- phase 4: random limits, stall limit kept small so drops stay frequent
    write_reg(csqr_pkg::CFG_RETRY_LIMIT, 8'($urandom));
    write_reg(csqr_pkg::CFG_STALL_LIMIT, 8'($urandom_range(6)));
    push_random(100, 35);
    drain();

    if (!failed && outcome_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
